FILE: src/bpc_pkg.sv
// Shared types and constants for the batched packed Cholesky factorizer.
package bpc_pkg;
    localparam int LANES = 4;
    localparam int IDX_W = 4;
    localparam int DATA_W = 32;
    localparam int ACC_W = 64;

    typedef struct packed {
        logic             start;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic             failed;
    } bpc_cmd_t;

    typedef struct packed {
        logic done;
        logic fail;
    } bpc_stat_t;
endpackage

FILE: src/bpc_lane.sv
// One factor lane: per-lane L store, multiply-accumulate, bit-serial sqrt and divide.
module bpc_lane #(
    parameter int MAX_N = 8,
    parameter int FRAC_BITS = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  bpc_pkg::bpc_cmd_t          cmd,
    input  logic [bpc_pkg::DATA_W-1:0] elem,
    output bpc_pkg::bpc_stat_t         stat,
    output logic [bpc_pkg::DATA_W-1:0] factor
);
    import bpc_pkg::*;

    localparam int TRI = MAX_N * (MAX_N + 1) / 2;
    localparam int ADDR_W = (TRI < 2) ? 1 : $clog2(TRI);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RD   = 4'd1;
    localparam logic [3:0] S_MUL  = 4'd2;
    localparam logic [3:0] S_ACC  = 4'd3;
    localparam logic [3:0] S_POST = 4'd4;
    localparam logic [3:0] S_SQRT = 4'd5;
    localparam logic [3:0] S_DIVI = 4'd6;
    localparam logic [3:0] S_DIV  = 4'd7;
    localparam logic [3:0] S_FIN  = 4'd8;

    function automatic logic [ADDR_W-1:0] tri_base(input logic [IDX_W-1:0] r);
        logic [2*IDX_W:0] p;
        p = {{(IDX_W+1){1'b0}}, r} * ({{(IDX_W+1){1'b0}}, r} + 1'b1);
        return ADDR_W'(p >> 1);
    endfunction

    logic [DATA_W-1:0] store_mem [TRI];
    logic [3:0]        state_reg, state_next;
    logic [IDX_W-1:0]  row_reg, col_reg, k_reg;
    logic              failed_reg, fail_reg;
    logic [ACC_W-1:0]  acc_reg, prod_reg, num_reg;
    logic [DATA_W-1:0] rda_reg, rdb_reg, val_reg, q_reg, d_reg;
    logic [35:0]       srem_reg;
    logic [DATA_W-1:0] drem_reg;
    logic              neg_reg;
    logic [6:0]        it_reg;
    logic [ADDR_W-1:0] addr_a, addr_b, addr_w;
    logic [ACC_W:0]    diff;
    logic [ACC_W-1:0]  acc_sub;
    logic [35:0]       srem_sh, strial;
    logic [DATA_W-1:0] drem_sh;
    logic [ACC_W-1:0]  acc_abs;

    always_comb
    begin
        addr_a = ADDR_W'(tri_base(row_reg) + ADDR_W'(k_reg));
        addr_b = (state_reg == S_POST) ? ADDR_W'(tri_base(col_reg) + ADDR_W'(col_reg))
                                       : ADDR_W'(tri_base(col_reg) + ADDR_W'(k_reg));
        addr_w = ADDR_W'(tri_base(row_reg) + ADDR_W'(col_reg));
        diff = {acc_reg[ACC_W-1], acc_reg} - {prod_reg[ACC_W-1], prod_reg};
        if (diff[ACC_W] != diff[ACC_W-1])
        begin
            acc_sub = diff[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end
        else
        begin
            acc_sub = diff[ACC_W-1:0];
        end
        srem_sh = {srem_reg[33:0], num_reg[ACC_W-1:ACC_W-2]};
        strial = {2'b00, q_reg, 2'b01};
        drem_sh = {drem_reg[DATA_W-2:0], num_reg[ACC_W-1]};
        acc_abs = acc_reg[ACC_W-1] ? (~acc_reg + 1'b1) : acc_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd.start)
                begin
                    if (cmd.failed)
                        state_next = S_FIN;
                    else if (cmd.col == '0)
                        state_next = S_POST;
                    else
                        state_next = S_RD;
                end
            end
            S_RD:   state_next = S_MUL;
            S_MUL:  state_next = S_ACC;
            S_ACC:  state_next = (k_reg + 1'b1 < col_reg) ? S_RD : S_POST;
            S_POST:
            begin
                if (row_reg != col_reg)
                    state_next = S_DIVI;
                else if (acc_reg[ACC_W-1] || acc_reg == '0)
                    state_next = S_FIN;
                else
                    state_next = S_SQRT;
            end
            S_SQRT: state_next = (it_reg == 7'd31) ? S_FIN : S_SQRT;
            S_DIVI: state_next = (rdb_reg[DATA_W-1] || rdb_reg == '0) ? S_FIN : S_DIV;
            S_DIV:  state_next = (it_reg == 7'd63) ? S_FIN : S_DIV;
            S_FIN:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        rda_reg <= store_mem[addr_a];
        rdb_reg <= store_mem[addr_b];
        if (state_reg == S_FIN)
            store_mem[addr_w] <= val_reg;
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (cmd.start)
                begin
                    row_reg    <= cmd.row;
                    col_reg    <= cmd.col;
                    failed_reg <= cmd.failed;
                    fail_reg   <= cmd.failed;
                    k_reg      <= '0;
                    val_reg    <= '0;
                    acc_reg    <= $signed({{(ACC_W-DATA_W){elem[DATA_W-1]}}, elem}) <<< FRAC_BITS;
                end
            end
            S_MUL: prod_reg <= ACC_W'($signed(rda_reg) * $signed(rdb_reg));
            S_ACC:
            begin
                acc_reg <= acc_sub;
                k_reg   <= k_reg + 1'b1;
            end
            S_POST:
            begin
                num_reg  <= acc_reg;
                srem_reg <= '0;
                q_reg    <= '0;
                it_reg   <= '0;
                if (row_reg == col_reg && (acc_reg[ACC_W-1] || acc_reg == '0))
                    fail_reg <= 1'b1;
            end
            S_SQRT:
            begin
                num_reg <= num_reg << 2;
                it_reg  <= it_reg + 1'b1;
                if (srem_sh >= strial)
                begin
                    srem_reg <= srem_sh - strial;
                    q_reg    <= {q_reg[DATA_W-2:0], 1'b1};
                end
                else
                begin
                    srem_reg <= srem_sh;
                    q_reg    <= {q_reg[DATA_W-2:0], 1'b0};
                end
                if (it_reg == 7'd31)
                begin
                    if (q_reg[DATA_W-2:0] == '0 && !(srem_sh >= strial))
                        fail_reg <= 1'b1;
                    else if (q_reg[DATA_W-2])
                        val_reg <= {1'b0, {(DATA_W-1){1'b1}}};
                    else
                        val_reg <= {q_reg[DATA_W-2:0], (srem_sh >= strial)};
                end
            end
            S_DIVI:
            begin
                d_reg    <= rdb_reg;
                num_reg  <= acc_abs;
                neg_reg  <= acc_reg[ACC_W-1];
                drem_reg <= '0;
                it_reg   <= '0;
            end
            S_DIV:
            begin
                it_reg <= it_reg + 1'b1;
                if (drem_sh >= d_reg)
                begin
                    drem_reg <= drem_sh - d_reg;
                    num_reg  <= {num_reg[ACC_W-2:0], 1'b1};
                end
                else
                begin
                    drem_reg <= drem_sh;
                    num_reg  <= {num_reg[ACC_W-2:0], 1'b0};
                end
            end
            S_FIN:
            begin
                if (failed_reg)
                    val_reg <= '0;
            end
            default: ;
        endcase
        if (state_reg == S_DIV && it_reg == 7'd63)
        begin
            if (neg_reg)
            begin
                if ({num_reg[ACC_W-2:0], drem_sh >= d_reg} > {{(ACC_W-DATA_W){1'b0}}, 1'b1,
                        {(DATA_W-1){1'b0}}})
                    val_reg <= {1'b1, {(DATA_W-1){1'b0}}};
                else
                    val_reg <= DATA_W'(~{num_reg[ACC_W-2:0], drem_sh >= d_reg} + 1'b1);
            end
            else
            begin
                if ({num_reg[ACC_W-2:0], drem_sh >= d_reg} > {{(ACC_W-DATA_W+1){1'b0}},
                        {(DATA_W-1){1'b1}}})
                    val_reg <= {1'b0, {(DATA_W-1){1'b1}}};
                else
                    val_reg <= DATA_W'({num_reg[ACC_W-2:0], drem_sh >= d_reg});
            end
        end
    end

    // idle lane holds its last factor and fail bit
    assign stat.done = (state_reg == S_IDLE);
    assign stat.fail = fail_reg;
    assign factor    = val_reg;
endmodule

FILE: src/batched_packed_cholesky.sv
// Top level: element sequencing, four factor lanes and the merge into one result transfer.
// factor_valid rises once every lane is idle again; the slowest lane sets when that happens.
// Throughput: one element at a time; the next is taken once the result transfer completes.
// Reset clears counters, fail bits and valid flags; matrix_size resets to 4.
module batched_packed_cholesky #(
    parameter int MAX_N = 8,
    parameter int FRAC_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        matrix_size_we,
    input  logic [3:0]  matrix_size_wdata,
    input  logic        elem_valid,
    output logic        elem_stall,
    input  logic [31:0] elem_lane0,
    input  logic [31:0] elem_lane1,
    input  logic [31:0] elem_lane2,
    input  logic [31:0] elem_lane3,
    output logic        factor_valid,
    input  logic        factor_stall,
    output logic [31:0] factor_lane0,
    output logic [31:0] factor_lane1,
    output logic [31:0] factor_lane2,
    output logic [31:0] factor_lane3,
    output logic [3:0]  fail_mask,
    output logic [2:0]  row_index,
    output logic [2:0]  col_index,
    output logic        matrix_last
);
    import bpc_pkg::*;

    logic [3:0]        size_reg;
    logic [IDX_W-1:0]  row_reg, col_reg, n_eff;
    logic [LANES-1:0]  failed_reg;
    logic              busy_reg, out_valid_reg, last_reg;
    logic [IDX_W-1:0]  orow_reg, ocol_reg;
    logic [DATA_W-1:0] ofac_reg [LANES];
    logic [LANES-1:0]  ofail_reg;
    logic [DATA_W-1:0] elem_vec [LANES];
    logic [DATA_W-1:0] fac_vec [LANES];
    bpc_stat_t         stat_vec [LANES];
    logic [LANES-1:0]  done_vec, fail_vec;
    logic              take;

    assign elem_vec[0] = elem_lane0;
    assign elem_vec[1] = elem_lane1;
    assign elem_vec[2] = elem_lane2;
    assign elem_vec[3] = elem_lane3;

    always_comb
    begin
        if (size_reg == '0)
            n_eff = IDX_W'(1);
        else if (size_reg > IDX_W'(MAX_N))
            n_eff = IDX_W'(MAX_N);
        else
            n_eff = size_reg;
    end

    assign elem_stall = busy_reg | out_valid_reg;
    assign take = elem_valid & ~elem_stall;

    for (genvar l = 0; l < LANES; l++)
    begin : g_lane
        bpc_cmd_t cmd;
        assign cmd.start  = take;
        assign cmd.row    = row_reg;
        assign cmd.col    = col_reg;
        assign cmd.failed = failed_reg[l];
        bpc_lane #(.MAX_N(MAX_N), .FRAC_BITS(FRAC_BITS)) u_lane (
            .clk    (clk),
            .rst_n  (rst_n),
            .cmd    (cmd),
            .elem   (elem_vec[l]),
            .stat   (stat_vec[l]),
            .factor (fac_vec[l])
        );
        assign done_vec[l] = stat_vec[l].done;
        assign fail_vec[l] = stat_vec[l].fail;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg      <= 4'd4;
            row_reg       <= '0;
            col_reg       <= '0;
            failed_reg    <= '0;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (factor_valid && !factor_stall)
                out_valid_reg <= 1'b0;
            if (matrix_size_we)
            begin
                size_reg   <= matrix_size_wdata;
                row_reg    <= '0;
                col_reg    <= '0;
                failed_reg <= '0;
            end
            else if (take)
            begin
                busy_reg <= 1'b1;
                if (row_reg + 1'b1 < n_eff)
                    row_reg <= row_reg + 1'b1;
                else if (col_reg + 1'b1 >= n_eff)
                begin
                    row_reg <= '0;
                    col_reg <= '0;
                end
                else
                begin
                    row_reg <= col_reg + 1'b1;
                    col_reg <= col_reg + 1'b1;
                end
            end
            else if (busy_reg && (&done_vec))
            begin
                busy_reg      <= 1'b0;
                out_valid_reg <= 1'b1;
                failed_reg    <= last_reg ? '0 : fail_vec;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            orow_reg <= row_reg;
            ocol_reg <= col_reg;
            last_reg <= (row_reg == n_eff - 1'b1) && (col_reg == n_eff - 1'b1);
        end
        if (busy_reg && (&done_vec))
        begin
            ofail_reg <= fail_vec;
            for (int l = 0; l < LANES; l++)
            begin
                ofac_reg[l] <= fail_vec[l] ? '0 : fac_vec[l];
            end
        end
    end

    assign factor_valid = out_valid_reg;
    assign factor_lane0 = ofac_reg[0];
    assign factor_lane1 = ofac_reg[1];
    assign factor_lane2 = ofac_reg[2];
    assign factor_lane3 = ofac_reg[3];
    assign fail_mask    = ofail_reg;
    assign row_index    = orow_reg[2:0];
    assign col_index    = ocol_reg[2:0];
    assign matrix_last  = last_reg;
endmodule

FILE: src/bpc_checker.sv
// Port-level checks for the batched packed Cholesky factorizer.
module bpc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        elem_valid,
    input logic        elem_stall,
    input logic        factor_valid,
    input logic        factor_stall,
    input logic [31:0] factor_lane0,
    input logic [3:0]  fail_mask,
    input logic [2:0]  row_index,
    input logic [2:0]  col_index,
    input logic        matrix_last
);
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        elem_valid && !elem_stall |=> elem_stall)
        else $error("second transfer taken while busy");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        factor_valid && factor_stall |=> factor_valid && $stable(factor_lane0))
        else $error("stalled result changed");
    a_last_diag: assert property (@(posedge clk) disable iff (!rst_n)
        factor_valid && matrix_last |-> row_index == col_index)
        else $error("last element off diagonal");
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        factor_valid && fail_mask[0] |-> factor_lane0 == 32'd0)
        else $error("failed lane not zero");
    a_lower: assert property (@(posedge clk) disable iff (!rst_n)
        factor_valid |-> row_index >= col_index)
        else $error("element above diagonal");
endmodule

bind batched_packed_cholesky bpc_checker u_bpc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .elem_valid   (elem_valid),
    .elem_stall   (elem_stall),
    .factor_valid (factor_valid),
    .factor_stall (factor_stall),
    .factor_lane0 (factor_lane0),
    .fail_mask    (fail_mask),
    .row_index    (row_index),
    .col_index    (col_index),
    .matrix_last  (matrix_last)
);

FILE: bench/tb_batched_packed_cholesky.sv
// Testbench for batched_packed_cholesky: random matrix streams checked against a built-in predictor.
module tb_batched_packed_cholesky;
    timeunit 1ns;
    timeprecision 1ps;

    import bpc_pkg::*;

    localparam int MAXN = 8;
    localparam int TRI = MAXN * (MAXN + 1) / 2;
    localparam int WD_LIMIT = 5000;

    typedef logic [LANES-1:0][31:0] lanes_t;

    typedef struct {
        lanes_t     factor;
        logic [3:0] mask;
        logic [2:0] row;
        logic [2:0] col;
        logic       last;
    } factor_t;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        matrix_size_we = 0;
    logic [3:0]  matrix_size_wdata = 0;
    logic        elem_valid = 0;
    logic        elem_stall;
    lanes_t      elem_bus = '0;
    logic        factor_valid;
    logic        factor_stall = 0;
    lanes_t      factor_bus;
    logic [3:0]  fail_mask;
    logic [2:0]  row_index;
    logic [2:0]  col_index;
    logic        matrix_last;

    lanes_t      pending_elems[$];
    factor_t     expected_factors[$];
    int          errors = 0;
    int          send_idle = 0;
    int          recv_idle = 0;
    logic        hold_start = 0;
    int          hold_cnt = 0;
    int          quiet_cycles = 0;

    // predictor state
    logic signed [31:0] l_store[LANES][TRI];
    int          cur_row = 0;
    int          cur_col = 0;
    logic [3:0]  lanes_bad = 0;
    logic [3:0]  size_reg = 4;

    always #6 clk = ~clk;

    batched_packed_cholesky u_top (
        .clk(clk), .rst_n(rst_n),
        .matrix_size_we(matrix_size_we), .matrix_size_wdata(matrix_size_wdata),
        .elem_valid(elem_valid), .elem_stall(elem_stall),
        .elem_lane0(elem_bus[0]), .elem_lane1(elem_bus[1]),
        .elem_lane2(elem_bus[2]), .elem_lane3(elem_bus[3]),
        .factor_valid(factor_valid), .factor_stall(factor_stall),
        .factor_lane0(factor_bus[0]), .factor_lane1(factor_bus[1]),
        .factor_lane2(factor_bus[2]), .factor_lane3(factor_bus[3]),
        .fail_mask(fail_mask), .row_index(row_index), .col_index(col_index),
        .matrix_last(matrix_last)
    );

    function automatic int order_n();
        if (size_reg == 0) return 1;
        if (size_reg > MAXN) return MAXN;
        return size_reg;
    endfunction

    function automatic int tri_slot(int i, int j);
        return i * (i + 1) / 2 + j;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r = 0;
        longint unsigned b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic factor_t factor_elem(lanes_t e);
        factor_t o;
        int n = order_n();
        longint acc, p, q, d;
        logic signed [65:0] diff;
        longint unsigned r;
        logic signed [31:0] v;
        for (int l = 0; l < LANES; l++) begin
            v = 0;
            if (!lanes_bad[l]) begin
                acc = longint'($signed(e[l])) <<< 16;
                for (int k = 0; k < cur_col; k++) begin
                    p = longint'(l_store[l][tri_slot(cur_row, k)]) *
                        longint'(l_store[l][tri_slot(cur_col, k)]);
                    diff = 66'(acc) - 66'(p);
                    if (diff > 66'sh7FFF_FFFF_FFFF_FFFF) acc = 64'sh7FFF_FFFF_FFFF_FFFF;
                    else if (diff < -66'sh8000_0000_0000_0000)
                        acc = 64'sh8000_0000_0000_0000;
                    else acc = diff[63:0];
                end
                if (cur_row == cur_col) begin
                    r = acc > 0 ? int_sqrt(acc) : 0;
                    if (r == 0) lanes_bad[l] = 1;
                    else v = r > 64'h7FFF_FFFF ? 32'h7FFF_FFFF : r[31:0];
                end else begin
                    d = l_store[l][tri_slot(cur_col, cur_col)];
                    if (d > 0) begin
                        q = acc / d;
                        if (q > 64'sh7FFF_FFFF) v = 32'h7FFF_FFFF;
                        else if (q < -64'sh8000_0000) v = 32'h8000_0000;
                        else v = q[31:0];
                    end
                end
            end
            l_store[l][tri_slot(cur_row, cur_col)] = v;
            o.factor[l] = v;
        end
        o.mask = lanes_bad;
        o.row = cur_row[2:0];
        o.col = cur_col[2:0];
        o.last = (cur_row == n - 1) && (cur_col == n - 1);
        if (cur_row + 1 < n) begin
            cur_row++;
        end else begin
            cur_col++;
            cur_row = cur_col;
            if (cur_col >= n) begin
                cur_row = 0;
                cur_col = 0;
                lanes_bad = 0;
            end
        end
        return o;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        errors++;
    endtask

    // sender
    always @(posedge clk) begin
        logic take;
        take = elem_valid && !elem_stall;
        if (take)
            expected_factors.push_back(factor_elem(elem_bus));
        if (!elem_valid || take) begin
            if (pending_elems.size() > 0 && $urandom_range(99) >= send_idle) begin
                elem_valid <= 1;
                elem_bus <= pending_elems.pop_front();
            end else begin
                elem_valid <= 0;
            end
        end
    end

    always @(posedge clk) begin
        if (hold_start) hold_cnt <= 300;
        else if (hold_cnt > 0) hold_cnt <= hold_cnt - 1;
    end

    // receiver and checker
    always @(posedge clk) begin
        factor_t want;
        if (factor_valid && !factor_stall) begin
            if (expected_factors.size() == 0) begin
                report_mismatch("unexpected transfer", {29'd0, row_index}, 0);
            end else begin
                want = expected_factors.pop_front();
                for (int l = 0; l < LANES; l++)
                    if (factor_bus[l] !== want.factor[l])
                        report_mismatch($sformatf("lane%0d", l), factor_bus[l], want.factor[l]);
                if (fail_mask !== want.mask)
                    report_mismatch("fail_mask", 32'(fail_mask), 32'(want.mask));
                if (row_index !== want.row)
                    report_mismatch("row_index", 32'(row_index), 32'(want.row));
                if (col_index !== want.col)
                    report_mismatch("col_index", 32'(col_index), 32'(want.col));
                if (matrix_last !== want.last)
                    report_mismatch("matrix_last", 32'(matrix_last), 32'(want.last));
            end
        end
        factor_stall <= (hold_cnt > 1) || ($urandom_range(99) < recv_idle);
    end

    always @(posedge clk) begin
        if ((elem_valid && !elem_stall) || (factor_valid && !factor_stall) || matrix_size_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WD_LIMIT) begin
            $display("batched_packed_cholesky test failed");
            $finish;
        end
    end

    task automatic write_size(logic [3:0] v);
        @(posedge clk);
        matrix_size_we <= 1;
        matrix_size_wdata <= v;
        @(posedge clk);
        matrix_size_we <= 0;
        size_reg = v;
        cur_row = 0;
        cur_col = 0;
        lanes_bad = 0;
    endtask

    // sampled at the falling edge, once every edge update has settled
    task automatic drain();
        do @(negedge clk);
        while (pending_elems.size() != 0 || elem_valid || expected_factors.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [31:0] pd_value(int n, int i, int j);
        logic [31:0] v;
        if (i == j) v = $urandom_range(n << 20, n << 16);
        else v = $urandom_range(1 << 16);
        if (i != j && $urandom_range(1)) v = -v;
        return v;
    endfunction

    // mostly well-conditioned matrices, some noise and bad diagonals
    task automatic push_matrices(int min_items);
        int n = order_n();
        int cnt = 0;
        lanes_t e;
        while (cnt < min_items) begin
            for (int j = 0; j < n; j++)
                for (int i = j; i < n; i++) begin
                    for (int l = 0; l < LANES; l++) begin
                        case ($urandom_range(19))
                            0: e[l] = $urandom;
                            1: e[l] = (i == j) ? -$urandom_range(1 << 16) : $urandom;
                            2: e[l] = (i == j) ? $urandom_range(1) : 32'h7FFF_FFFF;
                            default: e[l] = pd_value(n, i, j);
                        endcase
                    end
                    pending_elems.push_back(e);
                    cnt++;
                end
        end
    endtask

    initial begin
        lanes_t e;
        logic [3:0] sizes[12] = '{1, 8, 4, 0, 15, 2, 3, 5, 6, 7, 8, 3};
        repeat (2) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // reset size of 4, directed extremes
        foreach (e[l]) e[l] = 32'h7FFF_FFFF;
        pending_elems.push_back(e);
        foreach (e[l]) e[l] = 32'h8000_0000;
        pending_elems.push_back(e);
        pending_elems.push_back('0);
        pending_elems.push_back('1);
        e = {32'h0000_0001, 32'h0001_0000, 32'hFFFF_0000, 32'h7FFF_FFFF};
        repeat (6) pending_elems.push_back(e);
        drain();

        // order one: every element a diagonal
        write_size(1);
        e = {32'h7FFF_FFFF, 32'h0000_0001, 32'h8000_0000, 32'h0000_0000};
        pending_elems.push_back(e);
        e = {32'h0001_0000, 32'hFFFF_FFFF, 32'h0000_0004, 32'h0000_FFFF};
        pending_elems.push_back(e);
        drain();

        // size change partway through a matrix
        write_size(8);
        push_matrices(1);
        drain();
        pending_elems.push_back({4{32'h0004_0000}});
        pending_elems.push_back({4{32'h0001_0000}});
        pending_elems.push_back({4{32'hFFFF_0000}});
        drain();

        for (int p = 0; p < 12; p++) begin
            case (p % 4)
                0: begin send_idle = 0; recv_idle = 0; end
                1: begin send_idle = 45; recv_idle = 0; end
                2: begin send_idle = 0; recv_idle = 45; end
                default: begin send_idle = 36; recv_idle = 36; end
            endcase
            write_size(sizes[p]);
            push_matrices(36);
            if (p == 4) begin
                @(posedge clk);
                hold_start <= 1;
                @(posedge clk);
                hold_start <= 0;
            end
            drain();
        end

        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("batched_packed_cholesky test passed");
        else
            $display("batched_packed_cholesky test failed");
        $finish;
    end
endmodule

FILE: files.f
src/bpc_pkg.sv
src/bpc_lane.sv
src/batched_packed_cholesky.sv
src/bpc_checker.sv
bench/tb_batched_packed_cholesky.sv
